FILE: rtl/aging_priority_scheduler_core_macros.svh
// ---------------------------------------------------------------------------
// aging priority scheduler assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef AGING_PRIORITY_SCHEDULER_CORE_MACROS_SVH
`define AGING_PRIORITY_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication
`define APS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aps assertion failed");

// next-cycle implication
`define APS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aps assertion failed");

`endif

FILE: rtl/aps_pkg.sv
// ---------------------------------------------------------------------------
// aps_pkg
// types, codes and helpers of the aging priority scheduler
// ---------------------------------------------------------------------------
package aps_pkg;

  localparam int PRIO_W   = 6;
  localparam int PRIO_MIN = -20;
  localparam int PRIO_MAX = 20;

  typedef logic signed [PRIO_W-1:0] prio_t;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SET    = 2'd2,
    ACT_PICK   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  typedef struct packed {
    logic  match;
    logic  less;
    prio_t aged;
  } alu_res_t;

  function automatic prio_t clamp_prio(input logic signed [7:0] p);
    prio_t r;
    if (int'(p) > PRIO_MAX) begin
      r = prio_t'(PRIO_MAX);
    end else if (int'(p) < PRIO_MIN) begin
      r = prio_t'(PRIO_MIN);
    end else begin
      r = prio_t'(p);
    end
    return r;
  endfunction

endpackage

FILE: rtl/aps_ram.sv
// ---------------------------------------------------------------------------
// aps_ram
// generic simple dual-port ram, one write port, registered read port
// ---------------------------------------------------------------------------
module aps_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/aps_alu.sv
// ---------------------------------------------------------------------------
// aps_alu
// shared compare and aging unit applied to one table entry per step
// ---------------------------------------------------------------------------
module aps_alu #(
  parameter int IDENT_WIDTH = 8
) (
  input  logic [IDENT_WIDTH-1:0] ent_ident,
  input  aps_pkg::prio_t         ent_dyn,
  input  logic [IDENT_WIDTH-1:0] key_ident,
  input  aps_pkg::prio_t         ref_dyn,
  output aps_pkg::alu_res_t      res
);

  import aps_pkg::*;

  always_comb begin
    res.match = (ent_ident == key_ident);
    res.less  = (ent_dyn < ref_dyn);
    res.aged  = (ent_dyn > prio_t'(PRIO_MIN)) ? ent_dyn - prio_t'(1) : ent_dyn;
  end

endmodule

FILE: rtl/aging_priority_scheduler_core.sv
// operation: one transfer at a time; each entry visited on a pass is read through the table
// memory's registered read port before it is checked or written
// reset: synchronous active-low rst_n empties the table; entry memory is not cleared
`include "aging_priority_scheduler_core_macros.svh"
// ---------------------------------------------------------------------------
// aging_priority_scheduler_core
// ready table in insertion order with add, remove, set priority and an
// aging pick, walked by a sequencer through one memory and a shared unit
// ---------------------------------------------------------------------------
module aging_priority_scheduler_core #(
  parameter int MAX_TASKS   = 16,
  parameter int IDENT_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // task_ident[7:0], new_priority[15:8]
  input  logic [1:0]  in_tuser,  // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // status[1:0], picked_ident[9:2], zero[15:10]
  output logic        out_tuser  // picked_valid[0]
);

  import aps_pkg::*;

  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int ENT_W = IDENT_WIDTH + 2 * PRIO_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_AGE_RD,
    S_AGE_WR,
    S_DONE
  } state_t;

  state_t                 state_r;
  act_t                   act_r;
  logic [IDENT_WIDTH-1:0] key_r;
  prio_t                  prio_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [IDX_W-1:0]       idx_r;
  logic [IDX_W-1:0]       best_idx_r;
  prio_t                  best_dyn_r;
  logic [IDENT_WIDTH-1:0] best_ident_r;
  status_t                res_status_r;
  logic                   res_valid_r;
  logic [IDENT_WIDTH-1:0] res_ident_r;
  logic                   out_tvalid_r;
  logic [15:0]            out_tdata_r;
  logic                   out_tuser_r;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [ENT_W-1:0]       ram_wdata;
  logic [ENT_W-1:0]       ram_rdata;
  logic [IDENT_WIDTH-1:0] rd_ident;
  prio_t                  rd_stat;
  prio_t                  rd_dyn;
  alu_res_t               alu;
  logic                   last;
  logic                   full;

  assign rd_ident = ram_rdata[ENT_W-1 -: IDENT_WIDTH];
  assign rd_stat  = ram_rdata[2*PRIO_W-1 -: PRIO_W];
  assign rd_dyn   = ram_rdata[PRIO_W-1:0];
  assign last     = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);
  assign full     = (cnt_r == CNT_W'(MAX_TASKS));

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  aps_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_TASKS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  aps_alu #(
    .IDENT_WIDTH(IDENT_WIDTH)
  ) u_alu (
    .ent_ident(rd_ident),
    .ent_dyn  (rd_dyn),
    .key_ident(key_r),
    .ref_dyn  (best_dyn_r),
    .res      (alu)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_rdata;
    case (state_r)
      S_ADD: begin
        if (!full) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(cnt_r);
          ram_wdata = {key_r, prio_t'(0), prio_t'(0)};
        end
      end
      S_SCAN_CHK: begin
        if (act_r == ACT_SET && alu.match) begin
          ram_we    = 1'b1;
          ram_wdata = {rd_ident, prio_r, prio_r};
        end
      end
      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r - IDX_W'(1);
      end
      S_AGE_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {rd_ident, rd_stat, (idx_r == best_idx_r) ? rd_stat : alu.aged};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && state_r != S_DONE) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            act_r        <= act_t'(in_tuser);
            key_r        <= IDENT_WIDTH'(in_tdata[7:0]);
            prio_r       <= clamp_prio(in_tdata[15:8]);
            idx_r        <= '0;
            res_valid_r  <= 1'b0;
            res_ident_r  <= '0;
            if (act_t'(in_tuser) == ACT_ADD) begin
              res_status_r <= ST_OK;
              state_r      <= S_ADD;
            end else if (cnt_r == '0) begin
              res_status_r <= ST_ABSENT;
              state_r      <= S_DONE;
            end else begin
              res_status_r <= ST_OK;
              state_r      <= S_SCAN_RD;
            end
          end
        end
        S_ADD: begin
          if (full) begin
            res_status_r <= ST_FULL;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
          state_r <= S_DONE;
        end
        S_SCAN_RD: begin
          state_r <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (act_r == ACT_PICK) begin
            if (idx_r == '0 || alu.less) begin
              best_idx_r   <= idx_r;
              best_dyn_r   <= rd_dyn;
              best_ident_r <= rd_ident;
            end
            if (last) begin
              idx_r   <= '0;
              state_r <= S_AGE_RD;
            end else begin
              idx_r   <= idx_r + IDX_W'(1);
              state_r <= S_SCAN_RD;
            end
          end else if (alu.match) begin
            if (act_r == ACT_REMOVE) begin
              if (last) begin
                cnt_r   <= cnt_r - CNT_W'(1);
                state_r <= S_DONE;
              end else begin
                idx_r   <= idx_r + IDX_W'(1);
                state_r <= S_SHIFT_RD;
              end
            end else begin
              state_r <= S_DONE;
            end
          end else if (last) begin
            res_status_r <= ST_ABSENT;
            state_r      <= S_DONE;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= S_SCAN_RD;
          end
        end
        S_SHIFT_RD: begin
          state_r <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          if (last) begin
            cnt_r   <= cnt_r - CNT_W'(1);
            state_r <= S_DONE;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= S_SHIFT_RD;
          end
        end
        S_AGE_RD: begin
          state_r <= S_AGE_WR;
        end
        S_AGE_WR: begin
          if (last) begin
            res_valid_r <= 1'b1;
            res_ident_r <= best_ident_r;
            state_r     <= S_DONE;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= S_AGE_RD;
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {6'b0, 8'(res_ident_r), res_status_r};
            out_tuser_r  <= res_valid_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `APS_ASSERT_IMP(a_count_range, 1'b1, cnt_r <= CNT_W'(MAX_TASKS))
  `APS_ASSERT_NXT(a_count_step, 1'b1, cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + CNT_W'(1) || cnt_r + CNT_W'(1) == $past(cnt_r))
  `APS_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `APS_ASSERT_IMP(a_pick_ok, out_tvalid && out_tuser, out_tdata[1:0] == ST_OK)
  `APS_ASSERT_IMP(a_idx_in_table, state_r != S_IDLE && state_r != S_ADD && state_r != S_DONE, CNT_W'(idx_r) < cnt_r)

endmodule
